// ===== rtl/owik_pkg.sv =====
// ----------------------------------------------------------------------------
// owik_pkg
// Types and fixed constants shared by the three-wheel inverse kinematics.
// ----------------------------------------------------------------------------
package owik_pkg;

  typedef enum logic [1:0] {
    OP_SPEED = 2'd0,
    OP_DUTY  = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  typedef enum logic {
    CFG_LINEAR_GAIN  = 1'b0,
    CFG_ANGULAR_GAIN = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] linear_speed;
    logic signed [15:0] heading;
    logic signed [15:0] angular_speed;
  } cmd_t;

  typedef struct packed {
    logic signed [23:0] wheel_a;
    logic signed [23:0] wheel_b;
    logic signed [23:0] wheel_c;
    logic               clipped;
  } result_t;

  localparam int unsigned NUM_WHEELS   = 3;
  localparam int unsigned SPEED_W      = 32;
  localparam int unsigned OUT_W        = 24;
  localparam int          OUT_MAX      = 8388607;
  localparam int          OUT_MIN      = -8388608;
  localparam logic [31:0] GAIN_RESET   = 32'h0001_0000;

  localparam int          FULL_TURN    = 23040;
  localparam int          QUARTER_TURN = 5760;
  localparam int          WHEEL_OFFSET [NUM_WHEELS] = '{-9600, -1920, 5760};

  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam int unsigned     SERIES_TERMS = 12;
  localparam int unsigned     SERIES_DIV [SERIES_TERMS] =
    '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552};

endpackage

// ===== rtl/omni_wheel_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_inverse_kinematics
// Three-wheel omnidirectional base: base command to three wheel commands.
// ----------------------------------------------------------------------------
// A command is taken on every clock where start is high; busy stays low, so
// commands may come back to back. Each command produces one result on
// result_o, marked by done_o for one cycle. The command passes through a
// ten-stage pipeline: gain multiply, angle fold, reciprocal index scaling,
// registered cosine ROM read, speed-times-cosine multiply, rounding and
// saturation. The receiver cannot hold results off.
// Gain registers are written through the cfg channel, which is always ready.
module omni_wheel_inverse_kinematics #(
  parameter int unsigned COS_TABLE_DEPTH   = 256,
  parameter int unsigned COS_FRACTION_BITS = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  owik_pkg::cmd_t     cmd_i,
  output logic               done_o,
  output owik_pkg::result_t  result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  owik_pkg::cfg_reg_e cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import owik_pkg::*;

  localparam int unsigned CW    = COS_FRACTION_BITS + 1;
  localparam int unsigned PW    = SPEED_W + CW + 1;
  localparam int unsigned VCW   = PW + 1 - COS_FRACTION_BITS;
  localparam int unsigned SW    = VCW + 2;
  localparam int unsigned NSTG  = 10;
  localparam logic signed [SW-1:0] F_MAX = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] F_MIN = SW'(OUT_MIN);

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic [31:0] lin_gain_q, ang_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q <= GAIN_RESET;
      ang_gain_q <= GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LINEAR_GAIN:  lin_gain_q <= cfg_data_i;
        CFG_ANGULAR_GAIN: ang_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [NSTG-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], start & ~busy};
    end
  end

  assign done_o = vld_q[NSTG-1];

  // stage 1: capture command
  cmd_t cmd1_q;

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd1_q <= cmd_i;
    end
  end

  // stage 2: gain products
  logic signed [48:0] pv2_q, pw2_q;
  logic signed [15:0] v2_q, w2_q;
  logic [1:0]         op2_q;

  always_ff @(posedge clk_i) begin
    pv2_q <= 49'(cmd1_q.linear_speed) * $signed({1'b0, lin_gain_q});
    pw2_q <= 49'(cmd1_q.angular_speed) * $signed({1'b0, ang_gain_q});
    v2_q  <= cmd1_q.linear_speed;
    w2_q  <= cmd1_q.angular_speed;
    op2_q <= cmd1_q.opcode;
  end

  // stage 3: scaled speeds, then delay to line up with the cosine lanes
  logic signed [48:0]        pv_rnd, pw_rnd;
  logic signed [SPEED_W-1:0] v3_d, w3_d;
  logic signed [SPEED_W-1:0] v_dly_q [5];
  logic signed [SPEED_W-1:0] w_dly_q [7];
  logic [1:0]                op_dly_q [7];

  always_comb begin
    pv_rnd = (pv2_q + 49'sd32768) >>> 16;
    pw_rnd = (pw2_q + 49'sd32768) >>> 16;
    if (op2_q == OP_SPEED) begin
      v3_d = SPEED_W'(pv_rnd);
      w3_d = SPEED_W'(pw_rnd);
    end else begin
      v3_d = SPEED_W'(v2_q);
      w3_d = SPEED_W'(w2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    v_dly_q[0]  <= v3_d;
    w_dly_q[0]  <= w3_d;
    op_dly_q[0] <= op2_q;
    for (int i = 1; i < 5; i++) begin
      v_dly_q[i] <= v_dly_q[i-1];
    end
    for (int i = 1; i < 7; i++) begin
      w_dly_q[i]  <= w_dly_q[i-1];
      op_dly_q[i] <= op_dly_q[i-1];
    end
  end

  // stages 2 to 7: cosine lanes
  logic [CW-1:0] mag [NUM_WHEELS];
  logic          neg [NUM_WHEELS];

  for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
    owik_lane #(
      .COS_TABLE_DEPTH  (COS_TABLE_DEPTH),
      .COS_FRACTION_BITS(COS_FRACTION_BITS),
      .OFFSET           (WHEEL_OFFSET[g])
    ) u_lane (
      .clk_i    (clk_i),
      .heading_i(cmd1_q.heading),
      .mag_o    (mag[g]),
      .neg_o    (neg[g])
    );
  end

  // stage 8: speed times cosine magnitude; stage 9: sign and round
  logic signed [PW-1:0]  prod8_q [NUM_WHEELS];
  logic                  neg8_q  [NUM_WHEELS];
  logic signed [PW:0]    sp      [NUM_WHEELS];
  logic signed [PW:0]    sp_rnd  [NUM_WHEELS];
  logic signed [VCW-1:0] vc9_q   [NUM_WHEELS];

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      sp[i]     = neg8_q[i] ? -(PW+1)'(prod8_q[i]) : (PW+1)'(prod8_q[i]);
      sp_rnd[i] = (sp[i] + ((PW+1)'(1) <<< (COS_FRACTION_BITS - 1))) >>> COS_FRACTION_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      prod8_q[i] <= PW'(v_dly_q[4]) * PW'($signed({1'b0, mag[i]}));
      neg8_q[i]  <= neg[i];
      vc9_q[i]   <= VCW'(sp_rnd[i]);
    end
  end

  // stage 10: combine, saturate, present
  logic signed [SW-1:0]    f     [NUM_WHEELS];
  logic signed [OUT_W-1:0] wheel [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]   clip;
  logic [1:0]              op9;
  result_t                 result_d, result_q;

  always_comb begin
    op9 = op_dly_q[6];
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (op9 == OP_DUTY) begin
        f[i] = SW'(vc9_q[i]) + SW'(w_dly_q[6]);
      end else begin
        f[i] = -SW'(vc9_q[i]) - SW'(w_dly_q[6]);
      end
      if (f[i] > F_MAX) begin
        wheel[i] = OUT_W'(OUT_MAX);
        clip[i]  = 1'b1;
      end else if (f[i] < F_MIN) begin
        wheel[i] = OUT_W'(OUT_MIN);
        clip[i]  = 1'b1;
      end else begin
        wheel[i] = OUT_W'(f[i]);
        clip[i]  = 1'b0;
      end
    end
    if (op9 == OP_SPEED || op9 == OP_DUTY) begin
      result_d.wheel_a = wheel[0];
      result_d.wheel_b = wheel[1];
      result_d.wheel_c = wheel[2];
      result_d.clipped = |clip;
    end else begin
      result_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

// ===== rtl/owik_lane.sv =====
// ----------------------------------------------------------------------------
// owik_lane
// Per-wheel angle pipeline: reduce heading plus offset to one turn, fold to
// a quadrant, scale to a table index and read the quarter-wave cosine ROM.
// ----------------------------------------------------------------------------
module owik_lane #(
  parameter int unsigned COS_TABLE_DEPTH   = 256,
  parameter int unsigned COS_FRACTION_BITS = 15,
  parameter int          OFFSET            = 0
) (
  input  logic                         clk_i,
  input  logic signed [15:0]           heading_i,
  output logic [COS_FRACTION_BITS:0]   mag_o,
  output logic                         neg_o
);
  import owik_pkg::*;

  localparam int unsigned CW    = COS_FRACTION_BITS + 1;
  localparam int unsigned IW    = $clog2(COS_TABLE_DEPTH + 1);
  localparam int unsigned NW    =
    $clog2(QUARTER_TURN * COS_TABLE_DEPTH + QUARTER_TURN / 2 + 1);
  localparam longint unsigned RECIP = (64'd1 << 32) / QUARTER_TURN;
  localparam int unsigned RW    = $clog2(RECIP + 1);
  localparam int unsigned PRW   = NW + RW;

  function automatic logic [CW-1:0] cos_entry(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          c;
    x    = (HALF_PI_Q30 * 64'(k) + 64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = 64'd1 << 30;
    acc  = longint'(term);
    for (int t = 1; t <= SERIES_TERMS; t++) begin
      term = ((term * x2) >> 30) / 64'(SERIES_DIV[t-1]);
      if (t % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    c = (acc + (64'sd1 <<< (29 - COS_FRACTION_BITS))) >>> (30 - COS_FRACTION_BITS);
    return CW'(c);
  endfunction

  logic [CW-1:0] cos_rom [COS_TABLE_DEPTH+1];

  for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_rom
    assign cos_rom[k] = cos_entry(k);
  end

  // stage 2: angle reduced into one turn
  logic signed [17:0] sum;
  logic [16:0]        s;
  logic [14:0]        a_d, a_q;

  always_comb begin
    sum = 18'(heading_i) + 18'(OFFSET) + 18'(2 * FULL_TURN);
    s   = sum[16:0];
    if (s >= 17'(3 * FULL_TURN)) begin
      a_d = 15'(s - 17'(3 * FULL_TURN));
    end else if (s >= 17'(2 * FULL_TURN)) begin
      a_d = 15'(s - 17'(2 * FULL_TURN));
    end else if (s >= 17'(FULL_TURN)) begin
      a_d = 15'(s - 17'(FULL_TURN));
    end else begin
      a_d = 15'(s);
    end
  end

  // stage 3: quadrant fold
  logic [14:0] p;
  logic        odd;
  logic [12:0] pos_d, pos_q;
  logic        neg3_d;

  always_comb begin
    if (a_q >= 15'(3 * QUARTER_TURN)) begin
      p      = a_q - 15'(3 * QUARTER_TURN);
      odd    = 1'b1;
      neg3_d = 1'b0;
    end else if (a_q >= 15'(2 * QUARTER_TURN)) begin
      p      = a_q - 15'(2 * QUARTER_TURN);
      odd    = 1'b0;
      neg3_d = 1'b1;
    end else if (a_q >= 15'(QUARTER_TURN)) begin
      p      = a_q - 15'(QUARTER_TURN);
      odd    = 1'b1;
      neg3_d = 1'b1;
    end else begin
      p      = a_q;
      odd    = 1'b0;
      neg3_d = 1'b0;
    end
    pos_d = odd ? 13'(15'(QUARTER_TURN) - p) : 13'(p);
  end

  // stages 4 to 6: index = round(pos * depth / quarter turn)
  logic [NW-1:0]  n_d, n_q, n5_q;
  logic [PRW-1:0] prod_d, prod_q;
  logic [NW-1:0]  qx, r;
  logic [IW-1:0]  idx_d, idx_q;
  logic [4:0]     neg_q;

  always_comb begin
    n_d    = NW'(pos_q) * NW'(COS_TABLE_DEPTH) + NW'(QUARTER_TURN / 2);
    prod_d = PRW'(n_q) * PRW'(RECIP);
    qx     = NW'(prod_q >> 32);
    r      = n5_q - qx * NW'(QUARTER_TURN);
    idx_d  = IW'(qx) + IW'(r >= NW'(QUARTER_TURN));
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    pos_q  <= pos_d;
    n_q    <= n_d;
    prod_q <= prod_d;
    n5_q   <= n_q;
    idx_q  <= idx_d;
    mag_o  <= cos_rom[idx_q];
    neg_q  <= {neg_q[3:0], neg3_d};
  end

  assign neg_o = neg_q[4];

endmodule
